// ----- sv/sft_pkg.sv -----
package sft_pkg;

  // field widths
  localparam int TIME_W = 22;
  localparam int LEN_W  = 24;
  localparam int RCP_W  = 23;
  localparam int CFG_W  = 24;
  localparam int CFG_IDX_W = 2;

  // stream packing, first field in the lowest bits
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 144;
  localparam int ET_LSB  = 0;
  localparam int TX_LSB  = 22;
  localparam int TY_LSB  = 46;
  localparam int SX_LSB  = 70;
  localparam int SY_LSB  = 94;
  localparam int SZ_LSB  = 118;
  localparam int SVX_LSB = 142;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SWING_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_RECIP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APEX_HEIGHT  = 2'd2;

  // register reset values
  localparam logic [TIME_W-1:0] SWING_PERIOD_RST = 22'd314573;
  localparam logic [RCP_W-1:0]  PERIOD_RECIP_RST = 23'd873813;
  localparam logic signed [LEN_W-1:0] APEX_HEIGHT_RST = -24'sd65536;

  localparam int PHASE_TABLE_DEPTH_DEFAULT = 256;

  localparam int ONE_Q20 = 1 << 20;

  // phase table entry widths
  localparam int SIN_W = 20;
  localparam int OMC_W = 23;

  localparam longint PI_Q28         = 64'sd843314857;
  localparam longint TWO_PI_Q28     = 64'sd1686629714;
  localparam longint INV_TWO_PI_Q28 = 64'sd42722830;

  // sin(theta)/(2 pi) in Q.20, theta in Q.28 over one turn
  // taylor series to the x^21 term, divisors are (2n)(2n+1)
  function automatic logic signed [SIN_W-1:0] sin_entry(input longint theta);
    longint th;
    logic neg;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint s;
    th = theta;
    neg = 1'b0;
    if (th > PI_Q28) begin
      th = TWO_PI_Q28 - th;
      neg = 1'b1;
    end
    x = th;
    x2 = (x * x) >> 28;
    s = th;
    term = x;
    term = ((term * x2) >> 28) / 64'd6;
    s = s - longint'(term);
    term = ((term * x2) >> 28) / 64'd20;
    s = s + longint'(term);
    term = ((term * x2) >> 28) / 64'd42;
    s = s - longint'(term);
    term = ((term * x2) >> 28) / 64'd72;
    s = s + longint'(term);
    term = ((term * x2) >> 28) / 64'd110;
    s = s - longint'(term);
    term = ((term * x2) >> 28) / 64'd156;
    s = s + longint'(term);
    term = ((term * x2) >> 28) / 64'd210;
    s = s - longint'(term);
    term = ((term * x2) >> 28) / 64'd272;
    s = s + longint'(term);
    term = ((term * x2) >> 28) / 64'd342;
    s = s - longint'(term);
    term = ((term * x2) >> 28) / 64'd420;
    s = s + longint'(term);
    if (neg) begin
      s = -s;
    end
    return SIN_W'((s * INV_TWO_PI_Q28) >>> 36);
  endfunction

  // 1 - cos(theta) in Q.20, theta in Q.28 over one turn
  // taylor series to the x^22 term, divisors are (2n-1)(2n)
  function automatic logic signed [OMC_W-1:0] omc_entry(input longint theta);
    longint th;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint c;
    th = theta;
    if (th > PI_Q28) begin
      th = TWO_PI_Q28 - th;
    end
    x = th;
    x2 = (x * x) >> 28;
    c = 64'sd1 << 28;
    term = 64'd1 << 28;
    term = ((term * x2) >> 28) / 64'd2;
    c = c - longint'(term);
    term = ((term * x2) >> 28) / 64'd12;
    c = c + longint'(term);
    term = ((term * x2) >> 28) / 64'd30;
    c = c - longint'(term);
    term = ((term * x2) >> 28) / 64'd56;
    c = c + longint'(term);
    term = ((term * x2) >> 28) / 64'd90;
    c = c - longint'(term);
    term = ((term * x2) >> 28) / 64'd132;
    c = c + longint'(term);
    term = ((term * x2) >> 28) / 64'd182;
    c = c - longint'(term);
    term = ((term * x2) >> 28) / 64'd240;
    c = c + longint'(term);
    term = ((term * x2) >> 28) / 64'd306;
    c = c - longint'(term);
    term = ((term * x2) >> 28) / 64'd380;
    c = c + longint'(term);
    term = ((term * x2) >> 28) / 64'd462;
    c = c - longint'(term);
    return OMC_W'(longint'(ONE_Q20) - (c >>> 8));
  endfunction

  // clamp to the 24 bit output range
  function automatic logic signed [LEN_W-1:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[LEN_W-1:0];
  endfunction

endpackage

// ----- sv/sft_phase_rom.sv -----
module sft_phase_rom #(
  parameter int PHASE_TABLE_DEPTH = sft_pkg::PHASE_TABLE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic en,
  input  logic [$clog2(PHASE_TABLE_DEPTH)-1:0] addr,
  output logic signed [sft_pkg::SIN_W-1:0] sin_val,
  output logic signed [sft_pkg::OMC_W-1:0] omc_val
);
  import sft_pkg::*;

  logic signed [SIN_W-1:0] sin_tab [PHASE_TABLE_DEPTH];
  logic signed [OMC_W-1:0] omc_tab [PHASE_TABLE_DEPTH];

  // entry k sits at angle 2 pi k / depth
  for (genvar k = 0; k < PHASE_TABLE_DEPTH; k++) begin : g_entry
    localparam longint Theta = (TWO_PI_Q28 * k) / PHASE_TABLE_DEPTH;
    assign sin_tab[k] = sin_entry(Theta);
    assign omc_tab[k] = omc_entry(Theta);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= sin_tab[addr];
      omc_val <= omc_tab[addr];
    end
  end

endmodule

// ----- sv/swing_foot_trajectory.sv -----
// swing foot trajectory generator, one leg sample per item
// input channel s_*: one item holds elapsed swing time, landing targets,
//   start position and start forward velocity
// output channel m_*: one item holds desired position and velocity on the
//   forward, side and height axes, each saturated to 24 bits
// cfg_*: write-only register port (swing period, its reciprocal, apex
//   height); write only while no item is in flight
// six register stages from input to the output register: an item accepted
//   at one edge shows on m_tvalid five edges later when nothing stalls, so
//   it can be taken at the sixth
// throughput is one item per clock, set by the multiplier chain being
//   pipelined with one multiply per stage; the phase table is a registered
//   constant read in stage three
// when m_tready is low with a result waiting, the whole pipe holds and
//   s_tready drops; no item is lost or repeated
// rst (synchronous) empties the pipe and loads the register reset values;
//   the phase table is constant and needs no fill
// forward axis: quadratic, cubic, then hold; side axis: cycloid from the
//   table; height: cubic rise, parabolic descent
module swing_foot_trajectory #(
  parameter int PHASE_TABLE_DEPTH = sft_pkg::PHASE_TABLE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  // elapsed_time, target_x, target_y, start_x, start_y, start_z, start_vx, pad
  input  logic [sft_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic [sft_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  input  logic cfg_we,
  input  logic [sft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sft_pkg::CFG_W-1:0] cfg_data
);
  import sft_pkg::*;

  localparam int IDX_W = $clog2(PHASE_TABLE_DEPTH);

  // configuration registers
  logic [TIME_W-1:0] swing_period;
  logic [RCP_W-1:0] period_reciprocal;
  logic signed [LEN_W-1:0] apex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      swing_period <= SWING_PERIOD_RST;
      period_reciprocal <= PERIOD_RECIP_RST;
      apex_height <= APEX_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SWING_PERIOD: swing_period <= cfg_data[TIME_W-1:0];
        REG_PERIOD_RECIP: period_reciprocal <= cfg_data[RCP_W-1:0];
        REG_APEX_HEIGHT:  apex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [RCP_W:0] rcs;
  assign rcs = $signed({1'b0, period_reciprocal});

  // pipeline control: one valid bit per stage, whole pipe stalls together
  logic [5:0] vld;
  logic adv;
  assign adv = !vld[5] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], s_tvalid};
    end
  end

  // input fields
  logic [TIME_W-1:0] in_t;
  logic signed [LEN_W-1:0] in_tx, in_ty, in_x0, in_y0, in_z0, in_dx0;
  assign in_t   = s_tdata[ET_LSB +: TIME_W];
  assign in_tx  = s_tdata[TX_LSB +: LEN_W];
  assign in_ty  = s_tdata[TY_LSB +: LEN_W];
  assign in_x0  = s_tdata[SX_LSB +: LEN_W];
  assign in_y0  = s_tdata[SY_LSB +: LEN_W];
  assign in_z0  = s_tdata[SZ_LSB +: LEN_W];
  assign in_dx0 = s_tdata[SVX_LSB +: LEN_W];

  // ---- stage 1: phase, start offsets, segment choice ----
  logic [44:0] p_prod;
  logic signed [46:0] dt_prod, v_prod;
  assign p_prod  = 45'(in_t) * 45'(period_reciprocal);
  assign dt_prod = 47'(in_dx0) * 47'($signed({1'b0, in_t}));
  assign v_prod  = 47'(in_dx0) * 47'($signed({1'b0, swing_period}));

  logic [26:0] s1_p;
  logic signed [26:0] s1_dt, s1_v;
  logic signed [24:0] s1_d, s1_e, s1_dy;
  logic signed [LEN_W-1:0] s1_x0, s1_xt, s1_y0, s1_z0, s1_dx0;
  logic s1_c4, s1_c43, s1_c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p   <= p_prod[44:18];
      s1_dt  <= dt_prod[46:20];
      s1_v   <= v_prod[46:20];
      s1_c4  <= {1'b0, in_t, 2'b00} < 25'(swing_period);
      s1_c43 <= {1'b0, in_t, 2'b00} < (25'(swing_period) * 25'd3);
      s1_c2  <= {in_t, 1'b0} < {1'b0, swing_period};
      s1_d   <= 25'(in_x0) - 25'(in_tx);
      s1_e   <= 25'(in_z0) - 25'(apex_height);
      s1_dy  <= 25'(in_ty) - 25'(in_y0);
      s1_x0  <= in_x0;
      s1_xt  <= in_tx;
      s1_y0  <= in_y0;
      s1_z0  <= in_z0;
      s1_dx0 <= in_dx0;
    end
  end

  // ---- stage 2: clamped phase, table address, first products ----
  logic [20:0] pc_c;
  logic [IDX_W+19:0] frac_scaled;
  logic [53:0] pp_c;
  logic [41:0] pcpc_c;
  logic signed [29:0] m4;
  logic signed [30:0] m8, m8d;
  logic signed [56:0] qx_c;
  logic signed [54:0] qv_c;
  logic signed [55:0] vdesc_c;

  assign pc_c = (s1_p > 27'(ONE_Q20)) ? 21'(ONE_Q20) : s1_p[20:0];
  assign frac_scaled = (IDX_W+20)'(s1_p[19:0]) * (IDX_W+20)'(PHASE_TABLE_DEPTH);
  assign pp_c = 54'(s1_p) * 54'(s1_p);
  assign pcpc_c = 42'(pc_c) * 42'(pc_c);
  assign m4 = 30'sd1048576 - $signed({1'b0, s1_p, 2'b00});
  assign m8 = 31'sd1048576 - $signed({1'b0, s1_p, 3'b000});
  assign m8d = $signed({1'b0, s1_p, 3'b000}) - 31'sd4194304;
  assign qx_c = 57'(s1_dt) * 57'(m4);
  assign qv_c = 55'(s1_dx0) * 55'(m8);
  assign vdesc_c = 56'(s1_e) * 56'(m8d);

  logic [26:0] s2_p;
  logic [20:0] s2_pc, s2_p2;
  logic [IDX_W-1:0] s2_idx;
  logic [53:0] s2_pp;
  logic signed [31:0] s2_a, s2_b, s2_c, s2_k;
  logic signed [56:0] s2_qx;
  logic signed [54:0] s2_qv;
  logic signed [55:0] s2_vdesc;
  logic signed [24:0] s2_e, s2_dy;
  logic signed [LEN_W-1:0] s2_x0, s2_xt, s2_y0, s2_z0;
  logic s2_c4, s2_c43, s2_c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p     <= s1_p;
      s2_pc    <= pc_c;
      s2_p2    <= pcpc_c[40:20];
      s2_idx   <= frac_scaled[IDX_W+19:20];
      s2_pp    <= pp_c;
      s2_a     <= -32'sd4 * 32'(s1_v) + 32'sd16 * 32'(s1_d);
      s2_b     <= 32'sd7 * 32'(s1_v) - 32'sd24 * 32'(s1_d);
      s2_c     <= -32'sd15 * 32'(s1_v) + 32'sd36 * 32'(s1_d);
      s2_k     <= 32'sd9 * 32'(s1_v) + 32'sd16 * 32'(s1_xt);
      s2_qx    <= qx_c;
      s2_qv    <= qv_c;
      s2_vdesc <= vdesc_c;
      s2_e     <= s1_e;
      s2_dy    <= s1_dy;
      s2_x0    <= s1_x0;
      s2_xt    <= s1_xt;
      s2_y0    <= s1_y0;
      s2_z0    <= s1_z0;
      s2_c4    <= s1_c4;
      s2_c43   <= s1_c43;
      s2_c2    <= s1_c2;
    end
  end

  // ---- stage 3: table read, first horner step, rise products ----
  logic signed [SIN_W-1:0] s3_sin;
  logic signed [OMC_W-1:0] s3_omc;

  sft_phase_rom #(
    .PHASE_TABLE_DEPTH(PHASE_TABLE_DEPTH)
  ) u_rom (
    .clk(clk),
    .en(adv),
    .addr(s2_idx),
    .sin_val(s3_sin),
    .omc_val(s3_omc)
  );

  logic signed [21:0] pcs2;
  logic signed [39:0] a16, a48;
  logic signed [61:0] r1_prod, w1_prod;
  logic [41:0] p3_prod;
  logic signed [27:0] rise_v;
  logic signed [52:0] vzr_c;

  assign pcs2 = $signed({1'b0, s2_pc});
  assign a16 = 40'(s2_a) * 40'sd16;
  assign a48 = 40'(s2_a) * 40'sd48;
  assign r1_prod = 62'(a16) * 62'(pcs2);
  assign w1_prod = 62'(a48) * 62'(pcs2);
  assign p3_prod = 42'(s2_p2) * 42'(s2_pc);
  assign rise_v = 28'($signed({1'b0, s2_p2})) * 28'sd48 - 28'(pcs2) * 28'sd24;
  assign vzr_c = 53'(s2_e) * 53'(rise_v);

  logic [26:0] s3_p;
  logic [20:0] s3_pc, s3_p2, s3_p3;
  logic signed [39:0] s3_r1, s3_w1;
  logic signed [31:0] s3_c, s3_k;
  logic signed [34:0] s3_q, s3_qvx;
  logic signed [37:0] s3_qpx;
  logic signed [35:0] s3_vd1;
  logic signed [52:0] s3_vzr;
  logic signed [24:0] s3_e, s3_dy;
  logic signed [LEN_W-1:0] s3_xt, s3_y0, s3_z0;
  logic s3_c4, s3_c43, s3_c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_p   <= s2_p;
      s3_pc  <= s2_pc;
      s3_p2  <= s2_p2;
      s3_p3  <= p3_prod[40:20];
      s3_r1  <= 40'(r1_prod >>> 20) + 40'(s2_b) * 40'sd16;
      s3_w1  <= 40'(w1_prod >>> 20) + 40'(s2_b) * 40'sd32;
      s3_c   <= s2_c;
      s3_k   <= s2_k;
      s3_q   <= $signed({1'b0, s2_pp[53:20]}) - $signed(35'(s2_p));
      s3_qpx <= 38'(s2_x0) + 38'(s2_qx >>> 20);
      s3_qvx <= 35'(s2_qv >>> 20);
      s3_vd1 <= 36'(s2_vdesc >>> 20);
      s3_vzr <= vzr_c;
      s3_e   <= s2_e;
      s3_dy  <= s2_dy;
      s3_xt  <= s2_xt;
      s3_y0  <= s2_y0;
      s3_z0  <= s2_z0;
      s3_c4  <= s2_c4;
      s3_c43 <= s2_c43;
      s3_c2  <= s2_c2;
    end
  end

  // ---- stage 4: cycloid products, second horner step, height products ----
  logic signed [21:0] pcs3;
  logic signed [28:0] pms;
  logic signed [25:0] rise_p;
  logic signed [61:0] r2_prod, w2_prod;

  assign pcs3 = $signed({1'b0, s3_pc});
  assign pms = $signed(29'(s3_p)) - 29'(s3_sin);
  assign rise_p = 26'($signed({1'b0, s3_p3})) * 26'sd16
                - 26'($signed({1'b0, s3_p2})) * 26'sd12;
  assign r2_prod = 62'(s3_r1) * 62'(pcs3);
  assign w2_prod = 62'(s3_w1) * 62'(pcs3);

  logic [20:0] s4_pc;
  logic signed [53:0] s4_pyprod;
  logic signed [47:0] s4_vyprod;
  logic signed [39:0] s4_r2, s4_w2;
  logic signed [31:0] s4_k;
  logic signed [50:0] s4_pzr;
  logic signed [59:0] s4_pzd, s4_vzd;
  logic signed [32:0] s4_vzr1;
  logic signed [37:0] s4_qpx;
  logic signed [34:0] s4_qvx;
  logic signed [LEN_W-1:0] s4_xt, s4_y0, s4_z0;
  logic s4_c4, s4_c43, s4_c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pc     <= s3_pc;
      s4_pyprod <= 54'(s3_dy) * 54'(pms);
      s4_vyprod <= 48'(s3_dy) * 48'(s3_omc);
      s4_r2     <= 40'(r2_prod >>> 20) + 40'(s3_c) * 40'sd4;
      s4_w2     <= 40'(w2_prod >>> 20) + 40'(s3_c) * 40'sd4;
      s4_k      <= s3_k;
      s4_pzr    <= 51'(s3_e) * 51'(rise_p);
      s4_pzd    <= 60'(s3_e) * 60'(s3_q);
      s4_vzr1   <= 33'(s3_vzr >>> 20);
      s4_vzd    <= 60'(s3_vd1) * 60'(rcs);
      s4_qpx    <= s3_qpx;
      s4_qvx    <= s3_qvx;
      s4_xt     <= s3_xt;
      s4_y0     <= s3_y0;
      s4_z0     <= s3_z0;
      s4_c4     <= s3_c4;
      s4_c43    <= s3_c43;
      s4_c2     <= s3_c2;
    end
  end

  // ---- stage 5: last horner step, velocity scaling by reciprocal ----
  logic signed [61:0] r3_prod;
  assign r3_prod = 62'(s4_r2) * 62'($signed({1'b0, s4_pc}));

  logic signed [39:0] s5_r3;
  logic signed [63:0] s5_vxc;
  logic signed [34:0] s5_py;
  logic signed [27:0] s5_vy1;
  logic signed [42:0] s5_pz;
  logic signed [56:0] s5_vzr;
  logic signed [59:0] s5_vzd;
  logic signed [37:0] s5_qpx;
  logic signed [34:0] s5_qvx;
  logic signed [LEN_W-1:0] s5_xt;
  logic s5_c4, s5_c43, s5_c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r3  <= 40'(r3_prod >>> 20) + 40'(s4_k);
      s5_vxc <= 64'(s4_w2) * 64'(rcs);
      s5_py  <= 35'(s4_y0) + 35'(s4_pyprod >>> 20);
      s5_vy1 <= 28'(s4_vyprod >>> 20);
      if (s4_c2) begin
        s5_pz <= 43'(s4_z0) + 43'(s4_pzr >>> 20);
      end else begin
        s5_pz <= 43'(s4_z0) + 43'(s4_pzd >>> 18);
      end
      s5_vzr <= 57'(s4_vzr1) * 57'(rcs);
      s5_vzd <= s4_vzd;
      s5_qpx <= s4_qpx;
      s5_qvx <= s4_qvx;
      s5_xt  <= s4_xt;
      s5_c4  <= s4_c4;
      s5_c43 <= s4_c43;
      s5_c2  <= s4_c2;
    end
  end

  // ---- stage 6: segment select, saturation, output register ----
  logic signed [51:0] vy_prod;
  assign vy_prod = 52'(s5_vy1) * 52'(rcs);

  logic signed [LEN_W-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s5_c4) begin
        pos_x <= sat24(64'(s5_qpx));
        vel_x <= sat24(64'(s5_qvx));
      end else if (s5_c43) begin
        pos_x <= sat24(64'(s5_r3 >>> 4));
        vel_x <= sat24(s5_vxc >>> 22);
      end else begin
        // past three quarters: hold at the landing target
        pos_x <= s5_xt;
        vel_x <= '0;
      end
      pos_y <= sat24(64'(s5_py));
      vel_y <= sat24(64'(vy_prod >>> 18));
      pos_z <= sat24(64'(s5_pz));
      if (s5_c2) begin
        vel_z <= sat24(64'(s5_vzr >>> 18));
      end else begin
        vel_z <= sat24(64'(s5_vzd >>> 18));
      end
    end
  end

  assign m_tdata = {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipe valid bits moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipe not empty after reset");

  a_phase_clamp: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (s2_pc <= 21'(ONE_Q20)))
    else $error("clamped phase above one");
`endif

endmodule

// ----- tb/sv/swing_foot_trajectory_checker.sv -----
`timescale 1ns / 1ps

// watches both channels and the register port, predicts each sample and compares
module swing_foot_trajectory_checker #(
  parameter int DEPTH = sft_pkg::PHASE_TABLE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic [sft_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [sft_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic cfg_we,
  input  logic [sft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sft_pkg::CFG_W-1:0] cfg_data,
  output int errors,
  output int pending
);
  import sft_pkg::*;

  localparam longint Q20 = 64'sd1 << 20;

  longint sin_tab [DEPTH];
  longint omc_tab [DEPTH];
  longint period, recip, apex;
  logic [OUT_DATA_W-1:0] expected_samples [$];
  string field_names [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

  // sine / one-minus-cosine table over one turn, taylor series in q.28
  initial begin
    longint th, s, c;
    longint unsigned x, x2, term;
    logic neg;
    for (int k = 0; k < DEPTH; k++) begin
      th = (TWO_PI_Q28 * k) / DEPTH;
      neg = 1'b0;
      if (th > PI_Q28) begin
        th = TWO_PI_Q28 - th;
        neg = 1'b1;
      end
      x = th;
      x2 = (x * x) >> 28;
      s = th;
      term = x;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 28) / longint'((2 * n) * (2 * n + 1));
        s = n[0] ? s - longint'(term) : s + longint'(term);
      end
      c = 64'sd1 << 28;
      term = 64'd1 << 28;
      for (int n = 1; n <= 11; n++) begin
        term = ((term * x2) >> 28) / longint'((2 * n - 1) * (2 * n));
        c = n[0] ? c - longint'(term) : c + longint'(term);
      end
      if (neg) begin
        s = -s;
      end
      sin_tab[k] = (s * INV_TWO_PI_Q28) >>> 36;
      omc_tab[k] = Q20 - (c >>> 8);
    end
  end

  function automatic logic [LEN_W-1:0] clamp24(input longint v);
    if (v > 64'sd8388607) begin
      return 24'h7fffff;
    end else if (v < -64'sd8388608) begin
      return 24'h800000;
    end
    return v[LEN_W-1:0];
  endfunction

  // desired foot position and velocity for one sample
  function automatic logic [OUT_DATA_W-1:0] foot_sample(input logic [IN_DATA_W-1:0] d);
    longint t, xt, yt, x0, y0, z0, dx0;
    longint p, pc, px, vx, py, vy, pz, vz, e, dt;
    longint v, dd, a, b, c, k, r, w, p2, p3, q, idx;
    t = longint'(d[ET_LSB +: TIME_W]);
    xt = $signed(d[TX_LSB +: LEN_W]);
    yt = $signed(d[TY_LSB +: LEN_W]);
    x0 = $signed(d[SX_LSB +: LEN_W]);
    y0 = $signed(d[SY_LSB +: LEN_W]);
    z0 = $signed(d[SZ_LSB +: LEN_W]);
    dx0 = $signed(d[SVX_LSB +: LEN_W]);
    p = (t * recip) >>> 18;
    pc = (p > Q20) ? Q20 : p;

    // forward: quadratic, cubic, hold
    if (4 * t < period) begin
      dt = (dx0 * t) >>> 20;
      px = x0 + ((dt * (Q20 - 4 * p)) >>> 20);
      vx = (dx0 * (Q20 - 8 * p)) >>> 20;
    end else if (4 * t < 3 * period) begin
      v = (dx0 * period) >>> 20;
      dd = x0 - xt;
      a = -4 * v + 16 * dd;
      b = 7 * v - 24 * dd;
      c = -15 * v + 36 * dd;
      k = 9 * v + 16 * xt;
      r = 16 * a;
      w = 48 * a;
      r = ((r * pc) >>> 20) + 16 * b;
      r = ((r * pc) >>> 20) + 4 * c;
      r = ((r * pc) >>> 20) + k;
      px = r >>> 4;
      w = ((w * pc) >>> 20) + 32 * b;
      w = ((w * pc) >>> 20) + 4 * c;
      vx = (w * recip) >>> 22;
    end else begin
      px = xt;
      vx = 0;
    end

    // side: cycloid from the table
    idx = ((p & (Q20 - 1)) * DEPTH) >>> 20;
    py = y0 + (((yt - y0) * (p - sin_tab[idx])) >>> 20);
    vy = ((((yt - y0) * omc_tab[idx]) >>> 20) * recip) >>> 18;

    // height: cubic rise, parabolic descent
    e = z0 - apex;
    if (2 * t < period) begin
      p2 = (pc * pc) >>> 20;
      p3 = (p2 * pc) >>> 20;
      pz = z0 + ((e * (16 * p3 - 12 * p2)) >>> 20);
      vz = (((e * (48 * p2 - 24 * pc)) >>> 20) * recip) >>> 18;
    end else begin
      q = ((p * p) >>> 20) - p;
      pz = z0 + ((4 * e * q) >>> 20);
      vz = (((e * (8 * p - 4 * Q20)) >>> 20) * recip) >>> 18;
    end
    return {clamp24(vz), clamp24(vy), clamp24(vx), clamp24(pz), clamp24(py), clamp24(px)};
  endfunction

  assign pending = expected_samples.size();

  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    int bad;
    bad = 0;
    if (rst) begin
      period <= longint'(SWING_PERIOD_RST);
      recip <= longint'(PERIOD_RECIP_RST);
      apex <= longint'(APEX_HEIGHT_RST);
      errors <= 0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SWING_PERIOD: period <= longint'(cfg_data[TIME_W-1:0]);
          REG_PERIOD_RECIP: recip <= longint'(cfg_data[RCP_W-1:0]);
          REG_APEX_HEIGHT: apex <= $signed(cfg_data[LEN_W-1:0]);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_samples.push_back(foot_sample(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          $error("result item with nothing expected: %h", m_tdata);
          bad = bad + 1;
        end else begin
          want = expected_samples.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (m_tdata[f * LEN_W +: LEN_W] !== want[f * LEN_W +: LEN_W]) begin
              $error("%s: expected %0d, got %0d", field_names[f],
                     $signed(want[f * LEN_W +: LEN_W]), $signed(m_tdata[f * LEN_W +: LEN_W]));
              bad = bad + 1;
            end
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

// ----- tb/sv/swing_foot_trajectory_test.sv -----
`timescale 1ns / 1ps

module swing_foot_trajectory_test;
  import sft_pkg::*;

  localparam int IDLE_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off

  logic clk;
  logic rst;
  logic [IN_DATA_W-1:0] s_tdata;
  logic s_tvalid;
  logic s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int errors;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_req;
  int quiet_cycles;
  longint cur_period;  // mirror of the swing period register, for aiming times

  swing_foot_trajectory DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  swing_foot_trajectory_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("swing_foot_trajectory_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(
    input logic [TIME_W-1:0] t, input logic [LEN_W-1:0] xt, input logic [LEN_W-1:0] yt,
    input logic [LEN_W-1:0] x0, input logic [LEN_W-1:0] y0, input logic [LEN_W-1:0] z0,
    input logic [LEN_W-1:0] vx0);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[ET_LSB +: TIME_W] = t;
    d[TX_LSB +: LEN_W] = xt;
    d[TY_LSB +: LEN_W] = yt;
    d[SX_LSB +: LEN_W] = x0;
    d[SY_LSB +: LEN_W] = y0;
    d[SZ_LSB +: LEN_W] = z0;
    d[SVX_LSB +: LEN_W] = vx0;
    return d;
  endfunction

  // lengths: mostly full random, sometimes the extremes or small values
  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2, 3: return LEN_W'($signed($urandom_range(0, 131072)) - 65536);
      default: return LEN_W'($urandom);
    endcase
  endfunction

  // times: mostly up to a quarter past the swing, some at segment edges, some anywhere
  function automatic logic [TIME_W-1:0] rand_time();
    longint t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: t = $urandom_range(0, int'(cur_period + cur_period / 4));
      6, 7: t = ($urandom_range(1, 4) * cur_period) / 4 + $urandom_range(0, 4) - 2;
      default: t = $urandom_range(0, 4194303);
    endcase
    if (t < 0) begin
      t = 0;
    end
    return TIME_W'(t);
  endfunction

  task automatic send_item(input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk iff s_tready);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(pack_item(rand_time(), rand_len(), rand_len(), rand_len(), rand_len(),
                          rand_len(), rand_len()));
    end
  endtask

  // stop sending and wait for every result, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  // one register write; the caller drops cfg_we after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_SWING_PERIOD) begin
      cur_period = longint'(val[TIME_W-1:0]);
    end
  endtask

  task automatic set_timing(input longint period, input longint recip, input longint apex);
    write_reg(REG_SWING_PERIOD, CFG_W'(period));
    write_reg(REG_PERIOD_RECIP, CFG_W'(recip));
    write_reg(REG_APEX_HEIGHT, CFG_W'(apex));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_items();
    longint tq;
    tq = cur_period;
    // segment edges on the forward and height axes
    send_item(pack_item(0, 24'h010000, 24'h020000, 0, 0, 0, 24'h040000));
    send_item(pack_item(TIME_W'(tq / 4 - 1), 24'h010000, 24'hfe0000, 0, 0, 0, 24'h040000));
    send_item(pack_item(TIME_W'(tq / 4), 24'h010000, 24'hfe0000, 0, 0, 0, 24'h040000));
    send_item(pack_item(TIME_W'(tq / 2 - 1), 24'h030000, 24'h008000, 24'h001000, 0,
                        24'h002000, 24'hfc0000));
    send_item(pack_item(TIME_W'(tq / 2), 24'h030000, 24'h008000, 24'h001000, 0,
                        24'h002000, 24'hfc0000));
    send_item(pack_item(TIME_W'((3 * tq) / 4 - 1), 24'h030000, 24'h040000, 0, 0, 0, 0));
    send_item(pack_item(TIME_W'((3 * tq + 3) / 4), 24'h030000, 24'h040000, 0, 0, 0, 0));
    // end of swing: side axis lands on target
    send_item(pack_item(TIME_W'(tq), 24'h030000, 24'h040000, 0, 24'h010000, 0, 0));
    // time past the swing and the largest time
    send_item(pack_item(TIME_W'(tq * 2), 24'h030000, 24'h040000, 0, 0, 24'h010000, 0));
    send_item(pack_item(22'h3fffff, 24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                        24'h7fffff, 24'h7fffff));
    // field extremes
    send_item(pack_item(TIME_W'(tq / 8), 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000,
                        24'h800000, 24'h800000));
    send_item(pack_item(TIME_W'(tq / 3), 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
                        24'h7fffff, 24'h800000));
    send_item(pack_item(TIME_W'((2 * tq) / 3), 24'h800000, 24'h800000, 24'h7fffff,
                        24'h7fffff, 24'h800000, 24'h7fffff));
    send_item(pack_item(0, 0, 0, 0, 0, 0, 0));
    send_item(pack_item(22'h3fffff, 0, 0, 0, 0, 0, 0));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SWING_PERIOD;
    cfg_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_period = longint'(SWING_PERIOD_RST);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values, full rate
    directed_items();
    send_random(60);
    drain();

    // shortest nonzero swing, consistent reciprocal, lowest apex
    set_timing(52429, 5242870, -8388608);
    send_idle_pct = 55;
    directed_items();
    send_random(100);
    drain();

    // longest swing, highest apex; receiver stalls
    set_timing(2097152, 131072, 8388607);
    send_idle_pct = 0;
    recv_stall_pct = 55;
    send_random(100);
    drain();

    // reciprocal too large for the period: the phase clamp kicks in
    set_timing(314573, 5242880, -65536);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    directed_items();
    send_random(100);
    drain();

    // long receiver hold-off while items keep coming, so the pipe backs up
    set_timing(524288, 524288, 131072);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_random(100);
    drain();
    send_random(20);
    drain();

    // zero period: forward holds, height uses the descent
    set_timing(0, 873813, 65536);
    send_idle_pct = 55;
    recv_stall_pct = 55;
    send_random(60);
    drain();

    // mid values, mixed idling
    set_timing(786432, 349525, -262144);
    send_idle_pct = 28;
    recv_stall_pct = 55;
    directed_items();
    send_random(100);
    drain();

    set_timing(104858, 2621440, 0);
    send_idle_pct = 55;
    recv_stall_pct = 0;
    send_random(100);
    drain();

    if (errors == 0) begin
      $display("swing_foot_trajectory_test: PASS");
    end else begin
      $display("swing_foot_trajectory_test: FAIL");
    end
    $finish;
  end

endmodule
